>>> src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_seq and sorted_priority_queue; depends on nothing.
`default_nettype none

package spq_pkg;

    localparam int NUMBER_W = 17;
    localparam int PRIO_W   = 3;
    localparam int TIME_W   = 8;
    localparam int COUNT_W  = 5;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FRONT,
        ST_INSERT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]   req_time;
        logic [PRIO_W-1:0]   priority_lvl;
        logic [NUMBER_W-1:0] number;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   count;
        logic                 empty;
        t_entry               front;
    } t_result;

endpackage

`default_nettype wire

>>> src/spq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/spq_seq.sv
// Sequencer of the sorted priority queue: entry store, count, front copy
// and the one-entry-at-a-time shift/compare loop. Uses spq_pkg and spq_ram.
`default_nettype none

module spq_seq #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_op,
    input  wire spq_pkg::t_entry                i_entry,
    output logic                                o_res_valid,
    input  wire logic                           i_res_ready,
    output spq_pkg::t_result                    o_result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    spq_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_idx, n_idx;
    logic             r_op, n_op;
    spq_pkg::t_status r_status, n_status;
    spq_pkg::t_entry  r_front, n_front;
    spq_pkg::t_entry  r_new, n_new;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [spq_pkg::ENTRY_W-1:0] ram_wdata;
    logic [spq_pkg::ENTRY_W-1:0] ram_rdata;
    spq_pkg::t_entry           rd_entry;
    logic [CW+4:0]             cnt_wide;

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = spq_pkg::t_entry'(ram_rdata);
    assign cnt_wide = {{5{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_op     <= n_op;
        r_status <= n_status;
        r_front  <= n_front;
        r_new    <= n_new;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_op      = r_op;
        n_status  = r_status;
        n_front   = r_front;
        n_new     = r_new;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = rd_entry;
        o_ready   = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            spq_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op     = i_op;
                    n_new    = i_entry;
                    n_status = spq_pkg::STATUS_OK;
                    if (i_op == spq_pkg::OP_PUSH) begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_status = spq_pkg::STATUS_FULL;
                            n_state  = spq_pkg::ST_DONE;
                        end else if (r_count >= CW'(2)) begin
                            // Walk down from the back, moving entries up one slot.
                            n_idx   = AW'(r_count - 1'b1);
                            n_state = spq_pkg::ST_READ;
                        end else begin
                            n_state = spq_pkg::ST_FRONT;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = spq_pkg::STATUS_EMPTY;
                            n_state  = spq_pkg::ST_DONE;
                        end else if (r_count >= CW'(2)) begin
                            n_idx   = AW'(1);
                            n_state = spq_pkg::ST_READ;
                        end else begin
                            n_count = '0;
                            n_state = spq_pkg::ST_DONE;
                        end
                    end
                end
            end

            spq_pkg::ST_READ: begin
                n_state = spq_pkg::ST_CMP;
            end

            spq_pkg::ST_CMP: begin
                if (r_op == spq_pkg::OP_PUSH) begin
                    // The list stays sorted, so the first smaller priority from
                    // the back marks the insertion slot just above it.
                    if (rd_entry.priority_lvl >= r_new.priority_lvl) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_idx + 1'b1;
                        if (r_idx == AW'(1)) begin
                            n_state = spq_pkg::ST_FRONT;
                        end else begin
                            n_idx   = r_idx - 1'b1;
                            n_state = spq_pkg::ST_READ;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = spq_pkg::ST_INSERT;
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx - 1'b1;
                    if (r_idx == AW'(1)) begin
                        n_front = rd_entry;
                    end
                    if (CW'(r_idx) == r_count - 1'b1) begin
                        n_count = r_count - 1'b1;
                        n_state = spq_pkg::ST_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = spq_pkg::ST_READ;
                    end
                end
            end

            spq_pkg::ST_FRONT: begin
                // Slot one is free here. The front entry is passed only when
                // its priority is strictly greater than the new one.
                n_state = spq_pkg::ST_INSERT;
                if (r_count == '0) begin
                    n_idx = '0;
                end else if (r_front.priority_lvl <= r_new.priority_lvl) begin
                    n_idx = AW'(1);
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(1);
                    ram_wdata = r_front;
                    n_idx     = '0;
                end
            end

            spq_pkg::ST_INSERT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = r_new;
                if (r_idx == '0) begin
                    n_front = r_new;
                end
                n_count = r_count + 1'b1;
                n_state = spq_pkg::ST_DONE;
            end

            spq_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = spq_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.status = r_status;
        o_result.count  = cnt_wide[4:0];
        o_result.empty  = (r_count == '0);
        o_result.front  = (r_count == '0) ? '0 : r_front;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_status == spq_pkg::STATUS_FULL) |-> r_count == CW'(QUEUE_DEPTH))
        else $error("push dropped while queue not full");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_status == spq_pkg::STATUS_EMPTY) |-> r_count == '0)
        else $error("empty pop reported while entries are stored");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> CW'(ram_waddr) <= r_count)
        else $error("entry write beyond the stored range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_state != spq_pkg::ST_IDLE)
        else $error("sequencer idle right after taking a beat");
`endif

endmodule

`default_nettype wire

>>> src/sorted_priority_queue.sv
// Sorted priority queue: keeps up to QUEUE_DEPTH requests in ascending priority
// order in one RAM and answers every push or pop with one result beat (front
// request, count, status). One item is handled at a time. The work is done by a
// single RAM port pair that moves one entry at a time (read, then write back
// one slot over). A pop moves every entry behind the front one slot forward; a
// push moves entries from the second one onward one slot back to open the
// insertion slot. The result sits in an output register, so the next beat is
// accepted while a result still waits to be taken. Equal priorities go behind
// an equal front request but ahead of equal requests further back.
// Depends on spq_pkg and spq_seq.
`default_nettype none

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [16:0] request_number, [19:17] request_priority, [27:20] request_time
    input  wire logic [31:0] i_s_tdata,
    // [0] op
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [16:0] front_number, [19:17] front_priority, [27:20] front_time,
    // [28] queue_empty, [33:29] entry_count
    output logic      [39:0] o_m_tdata,
    // [1:0] status
    output logic      [1:0]  o_m_tuser
);

    spq_pkg::t_entry  in_entry;
    spq_pkg::t_result seq_result;
    spq_pkg::t_result r_out;
    logic             seq_res_valid;
    logic             res_ready;
    logic             r_out_valid;

    assign in_entry.number       = i_s_tdata[16:0];
    assign in_entry.priority_lvl = i_s_tdata[19:17];
    assign in_entry.req_time     = i_s_tdata[27:20];

    spq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_op        (i_s_tuser),
        .i_entry     (in_entry),
        .o_res_valid (seq_res_valid),
        .i_res_ready (res_ready),
        .o_result    (seq_result)
    );

    // The output register takes a new result when it is empty or draining.
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= seq_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && seq_res_valid) begin
            r_out <= seq_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out.count, r_out.empty, r_out.front.req_time,
                         r_out.front.priority_lvl, r_out.front.number};
    assign o_m_tuser  = r_out.status;

endmodule

`default_nettype wire
